### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/chrlcd_pkg.sv
// Package for the character LCD nibble sequencer: types, codes and microcode.
package chrlcd_pkg;

  localparam int TICKS_W              = 20;
  localparam int HOLD_W               = 5;
  localparam int PC_W                 = 5;
  localparam int CLOCK_MHZ_FACTOR_DEF = 50;

  // Operation codes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_CHAR   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Fixed bytes
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] ROW0_BASE   = 8'h80;
  localparam logic [7:0] ROW1_BASE   = 8'hC0;
  localparam logic [7:0] DDRAM_FLAG  = 8'h80;

  // Microcode entry points
  localparam logic [PC_W-1:0] PC_INIT      = 5'd0;
  localparam logic [PC_W-1:0] PC_INIT_END  = 5'd21;
  localparam logic [PC_W-1:0] PC_BYTE      = 5'd22;
  localparam logic [PC_W-1:0] PC_BYTE_END  = 5'd25;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        data_nibble;
    logic              reg_select;
    logic              enable;
    logic [HOLD_W-1:0] hold_ms;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {NIB_KEEP, NIB_HIGH, NIB_LOW} nib_sel_t;

  // One control word per sequencer step
  typedef struct packed {
    logic              use_const;
    logic [7:0]        const_byte;
    nib_sel_t          nib_sel;
    logic              en;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } ucode_t;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_EMIT, ST_HOLD} seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } timer_status_t;

  // Initialisation command list
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h06;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

  // One byte transfer phase: nibble, strobe level and hold
  function automatic ucode_t byte_phase(input logic [1:0] ph, input logic use_const,
                                        input logic [7:0] cbyte, input logic is_last);
    ucode_t w;
    w.use_const  = use_const;
    w.const_byte = cbyte;
    w.nib_sel    = ph[1] ? NIB_LOW : NIB_HIGH;
    w.en         = ~ph[0];
    w.hold       = (ph == 2'd3) ? HOLD_W'(2) : HOLD_W'(1);
    w.last       = is_last;
    return w;
  endfunction

  // Read-only control store
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t     w;
    logic [4:0] k;
    k = pc - 5'd1;
    w = '0;
    priority if (pc == PC_INIT) begin
      w.nib_sel = NIB_KEEP;
      w.hold    = HOLD_W'(20);
    end else if (pc < PC_INIT_END) begin
      w = byte_phase(k[1:0], 1'b1, init_cmd(k[4:2]), 1'b0);
    end else if (pc == PC_INIT_END) begin
      w.nib_sel = NIB_KEEP;
      w.hold    = HOLD_W'(2);
      w.last    = 1'b1;
    end else if (pc <= PC_BYTE_END) begin
      k = pc - PC_BYTE;
      w = byte_phase(k[1:0], 1'b0, 8'h00, pc == PC_BYTE_END);
    end else begin
      w.nib_sel = NIB_KEEP;
      w.hold    = HOLD_W'(1);
      w.last    = 1'b1;
    end
    return w;
  endfunction

endpackage

### rtl/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD nibble sequencer (4-bit bus, microcoded).
//
// Input channel (in_valid / in_stall / in_data) takes one operation per
// transaction: init, command byte, character, cursor move or clear. Codes
// 5 to 7 are taken and dropped. Output channel (out_valid / out_stall /
// out_data) gives the pin states in order, each with its hold time; last
// marks the final pin state of an operation.
// A step counter walks a read-only control store: init is 22 steps, every
// other operation 4 steps. Each pin state is loaded, then offered, and once
// taken is held by the hold timer for hold_ms milliseconds, scaled by
// ticks_per_ms. in_stall stays high until the last hold ends. A stalled
// result holds its payload and the sequencer waits on it. ticks_per_ms is
// written through cfg_write / cfg_data; the user must write it only while
// idle, as the block does not enforce this.
// Reset (synchronous) returns to idle, clears the pins and loads
// ticks_per_ms with CLOCK_MHZ_FACTOR * 1000.
module char_lcd_nibble_sequencer_top #(
  parameter int CLOCK_MHZ_FACTOR = chrlcd_pkg::CLOCK_MHZ_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  chrlcd_pkg::in_item_t           in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output chrlcd_pkg::out_item_t          out_data,
  input  logic                           cfg_write,
  input  logic [chrlcd_pkg::TICKS_W-1:0] cfg_data
);
  import chrlcd_pkg::*;

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(CLOCK_MHZ_FACTOR * 1000);

  seq_state_t     state, state_next;
  logic [PC_W-1:0] pc;
  logic [7:0]     operand;
  logic           op_rs;
  logic [3:0]     pin_nibble;
  logic           pin_rs;
  logic [TICKS_W-1:0] ticks_per_ms;

  ucode_t         uw;
  logic [7:0]     cur_byte;
  logic [3:0]     nib_new;
  logic           rs_new;
  logic           in_take;
  logic           op_known;
  logic           timer_start;
  timer_status_t  tstat;
  logic [PC_W-1:0] entry_pc;
  logic [7:0]     entry_byte;
  logic           entry_rs;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= TICKS_RESET;
    end else if (cfg_write) begin
      ticks_per_ms <= cfg_data;
    end
  end

  // Dispatch: entry step and operand byte per operation
  always_comb begin
    op_known   = 1'b1;
    entry_pc   = PC_BYTE;
    entry_byte = in_data.byte_value;
    entry_rs   = 1'b0;
    unique case (in_data.operation)
      OP_INIT:   entry_pc = PC_INIT;
      OP_CMD:    entry_rs = 1'b0;
      OP_CHAR:   entry_rs = 1'b1;
      OP_CURSOR: entry_byte = ((in_data.row ? ROW1_BASE : ROW0_BASE)
                               + {2'b00, in_data.col}) | DDRAM_FLAG;
      OP_CLEAR:  entry_byte = CMD_CLEAR;
      default:   op_known = 1'b0;
    endcase
  end

  // Datapath driven by the current control word
  always_comb begin
    uw       = ucode(pc);
    cur_byte = uw.use_const ? uw.const_byte : operand;
    nib_new  = pin_nibble;
    rs_new   = pin_rs;
    unique case (uw.nib_sel)
      NIB_HIGH: begin
        nib_new = cur_byte[7:4];
        rs_new  = op_rs;
      end
      NIB_LOW: begin
        nib_new = cur_byte[3:0];
        rs_new  = op_rs;
      end
      default: begin
        nib_new = pin_nibble;
        rs_new  = pin_rs;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_valid = (state == ST_EMIT);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next  = state;
    timer_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_take && op_known) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          timer_start = 1'b1;
          state_next  = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (tstat.done) state_next = out_data.last ? ST_IDLE : ST_LOAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Step counter, operand and pin registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= PC_INIT;
      pin_nibble <= '0;
      pin_rs     <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_take) begin
        pc      <= entry_pc;
        operand <= entry_byte;
        op_rs   <= entry_rs;
      end else if (state == ST_HOLD && tstat.done && !out_data.last) begin
        pc <= pc + PC_W'(1);
      end
      if (state == ST_LOAD) begin
        pin_nibble <= nib_new;
        pin_rs     <= rs_new;
      end
    end
  end

  // Result register, loaded once per step
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      out_data.data_nibble <= nib_new;
      out_data.reg_select  <= rs_new;
      out_data.enable      <= uw.en;
      out_data.hold_ms     <= uw.hold;
      out_data.last        <= uw.last;
    end
  end

  chrlcd_hold_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .ticks_per_ms (ticks_per_ms),
    .start        (timer_start),
    .hold_ms      (out_data.hold_ms),
    .status       (tstat)
  );

endmodule

### rtl/chrlcd_hold_timer.sv
// Hold timer: counts down hold_ms milliseconds, each measured by ticks_per_ms.
module chrlcd_hold_timer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [chrlcd_pkg::TICKS_W-1:0] ticks_per_ms,
  input  logic                           start,
  input  logic [chrlcd_pkg::HOLD_W-1:0]  hold_ms,
  output chrlcd_pkg::timer_status_t      status
);
  import chrlcd_pkg::*;

  logic [TICKS_W-1:0] tick_left;
  logic [HOLD_W-1:0]  ms_left;

  // Nested countdown: ticks within a millisecond, then milliseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        tick_left <= ticks_per_ms - TICKS_W'(1);
        ms_left   <= hold_ms;
        if (hold_ms == '0) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end else begin
          status.busy <= 1'b1;
        end
      end else if (status.busy) begin
        if (tick_left == '0) begin
          if (ms_left <= HOLD_W'(1)) begin
            status.busy <= 1'b0;
            status.done <= 1'b1;
          end else begin
            ms_left   <= ms_left - HOLD_W'(1);
            tick_left <= ticks_per_ms - TICKS_W'(1);
          end
        end else begin
          tick_left <= tick_left - TICKS_W'(1);
        end
      end
    end
  end

endmodule

### rtl/chrlcd_checker.sv
// Port-level checker for the sequencer, bound to the top level.
`include "assert_macros.svh"

module chrlcd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input chrlcd_pkg::out_item_t          out_data
);
  import chrlcd_pkg::*;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // A stalled pin state stays offered and unchanged
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  // No new operation is taken while a pin state is offered
  `CHK_IMPLY(a_busy_emit, out_valid, in_stall, "input taken during emit")
  // A pin state is never offered in the cycle after an operation is taken
  `CHK_NEXT(a_no_early, in_acc, !out_valid, "result too early")
  // Each taken pin state is followed by its hold
  `CHK_NEXT(a_hold_gap, out_acc, !out_valid, "no hold after result")
  // The operation is still running after a non-final pin state
  `CHK_NEXT(a_mid_busy, out_acc && !out_data.last, in_stall, "input freed mid-operation")

endmodule

bind char_lcd_nibble_sequencer_top chrlcd_checker u_chrlcd_checker (.*);

### test/tb.sv
// Self-checking testbench for the character LCD nibble sequencer.
`timescale 1ns / 1ps

import chrlcd_pkg::*;

// Predicts the pin states for each accepted operation and checks them in order.
class lcd_pin_scoreboard;
  localparam logic [7:0] CMD_HOME_4BIT  = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [HOLD_W-1:0] HOLD_POWER_UP = 5'd20;
  localparam logic [HOLD_W-1:0] HOLD_STROBE   = 5'd1;
  localparam logic [HOLD_W-1:0] HOLD_SETTLE   = 5'd2;
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  out_item_t  pin_q[$];
  logic [3:0] nibble;
  logic       rs;
  logic [4:0] steps;
  logic [7:0] last_byte;
  int         ticks;
  int         errors;
  int         seen;

  function new();
    nibble    = '0;
    rs        = 1'b0;
    steps     = '0;
    last_byte = '0;
    ticks     = CLOCK_MHZ_FACTOR_DEF * 1000;
    errors    = 0;
    seen      = 0;
  endfunction

  function int outstanding();
    return pin_q.size();
  endfunction

  function void drive_pins(logic en, logic [HOLD_W-1:0] ms);
    out_item_t p;
    p.data_nibble = nibble;
    p.reg_select  = rs;
    p.enable      = en;
    p.hold_ms     = ms;
    p.last        = 1'b0;
    pin_q.push_back(p);
  endfunction

  // High nibble strobed, then low nibble strobed with the longer settle hold
  function void send_byte(logic [7:0] b, logic sel);
    last_byte = b;
    rs        = sel;
    nibble    = b[7:4];
    drive_pins(1'b1, HOLD_STROBE);
    drive_pins(1'b0, HOLD_STROBE);
    nibble    = b[3:0];
    drive_pins(1'b1, HOLD_STROBE);
    drive_pins(1'b0, HOLD_SETTLE);
  endfunction

  function void note_item(in_item_t it);
    int         first_n;
    out_item_t  tail;
    logic [7:0] addr;
    first_n = pin_q.size();
    case (it.operation)
      OP_INIT: begin
        // waits keep the pins as last driven, enable low
        drive_pins(1'b0, HOLD_POWER_UP);
        send_byte(CMD_HOME_4BIT, RS_COMMAND);
        send_byte(CMD_FUNC_SET, RS_COMMAND);
        send_byte(CMD_DISPLAY_ON, RS_COMMAND);
        send_byte(CMD_ENTRY_MODE, RS_COMMAND);
        send_byte(CMD_CLEAR, RS_COMMAND);
        drive_pins(1'b0, HOLD_SETTLE);
      end
      OP_CMD:  send_byte(it.byte_value, RS_COMMAND);
      OP_CHAR: send_byte(it.byte_value, RS_DATA);
      OP_CURSOR: begin
        addr = (it.row ? ROW1_BASE : ROW0_BASE) + {2'b00, it.col};
        send_byte(addr | DDRAM_FLAG, RS_COMMAND);
      end
      OP_CLEAR: send_byte(CMD_CLEAR, RS_COMMAND);
      default: ;  // unused codes are dropped, state kept
    endcase
    if (pin_q.size() > first_n) begin
      tail      = pin_q.pop_back();
      tail.last = 1'b1;
      pin_q.push_back(tail);
      steps     = 5'(pin_q.size() - first_n);
    end
  endfunction

  function void mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: pin state %0d field %s expected %0h actual %0h",
             $time, seen, field, want, got);
    errors++;
  endfunction

  function void check_pin(out_item_t got);
    out_item_t want;
    if (pin_q.size() == 0) begin
      $display("%0t: unexpected pin state: expected none, actual %p", $time, got);
      errors++;
      return;
    end
    want = pin_q.pop_front();
    if (got.data_nibble !== want.data_nibble)
      mismatch("data_nibble", want.data_nibble, got.data_nibble);
    if (got.reg_select !== want.reg_select)
      mismatch("reg_select", want.reg_select, got.reg_select);
    if (got.enable !== want.enable)
      mismatch("enable", want.enable, got.enable);
    if (got.hold_ms !== want.hold_ms)
      mismatch("hold_ms", want.hold_ms, got.hold_ms);
    if (got.last !== want.last)
      mismatch("last", want.last, got.last);
    seen++;
  endfunction
endclass

module tb;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [TICKS_W-1:0] TICKS_MAX = 20'd1000000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_write = 1'b0;
  logic [TICKS_W-1:0]  cfg_data  = '0;

  lcd_pin_scoreboard sb;
  bit calm      = 1'b0;   // no idling on either side
  bit tail_real = 1'b0;   // last transaction started a pin sequence
  int stall_left = 0;

  char_lcd_nibble_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pin(out_data);
  end

  function automatic in_item_t lcd_op(logic [2:0] op, logic [7:0] b, logic r, logic [5:0] c);
    in_item_t it;
    it.operation  = op;
    it.byte_value = b;
    it.row        = r;
    it.col        = c;
    return it;
  endfunction

  // Mostly well-formed operations, a few unused codes as noise
  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    pick          = $urandom_range(0, 99);
    it.byte_value = 8'($urandom);
    it.row        = 1'($urandom);
    it.col        = 6'($urandom);
    if (pick < 8)       it.operation = OP_INIT;
    else if (pick < 31) it.operation = OP_CMD;
    else if (pick < 54) it.operation = OP_CHAR;
    else if (pick < 77) it.operation = OP_CURSOR;
    else if (pick < 90) it.operation = OP_CLEAR;
    else it.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    return it;
  endfunction

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_item(in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data  <= rand_item();
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    tail_real = (it.operation <= OP_CLEAR);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // All results in, then the last hold runs out
  task automatic settle();
    drain();
    repeat (tail_real ? 2 * sb.ticks + 20 : 20) @(posedge clk);
  endtask

  task automatic write_ticks(logic [TICKS_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.ticks = int'(v);
  endtask

  task automatic random_chunk(int n);
    in_item_t it;
    int       done_n;
    done_n = 0;
    while (done_n < n) begin
      it = rand_item();
      send_item(it);
      if (it.operation <= OP_CLEAR) done_n++;
      if (!calm && (done_n == n / 2 || $urandom_range(0, 24) == 0)) drain();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset timing: one character
    send_item(lcd_op(OP_CHAR, 8'hA5, 1'b0, 6'd0));
    settle();

    // slowest setting, dropped code only
    write_ticks(TICKS_MAX);
    send_item(lcd_op(OP_LAST_UNUSED, 8'h00, 1'b0, 6'd0));
    settle();

    // directed operations at the fastest setting
    write_ticks(20'd1);
    send_item(lcd_op(OP_FIRST_UNUSED, 8'hFF, 1'b1, 6'h3F));
    send_item(lcd_op(OP_INIT, 8'h00, 1'b0, 6'd0));
    send_item(lcd_op(OP_CMD, 8'h00, 1'b0, 6'd0));
    send_item(lcd_op(OP_CMD, 8'hFF, 1'b1, 6'h3F));
    send_item(lcd_op(OP_CHAR, 8'h00, 1'b0, 6'd0));
    send_item(lcd_op(OP_CHAR, 8'hFF, 1'b1, 6'h3F));
    send_item(lcd_op(OP_CHAR, 8'h5A, 1'b0, 6'h15));
    send_item(lcd_op(OP_CURSOR, 8'hFF, 1'b0, 6'd0));
    send_item(lcd_op(OP_CURSOR, 8'h00, 1'b0, 6'd39));
    send_item(lcd_op(OP_CURSOR, 8'h00, 1'b0, 6'h3F));
    send_item(lcd_op(OP_CURSOR, 8'h00, 1'b1, 6'd0));
    send_item(lcd_op(OP_CURSOR, 8'hFF, 1'b1, 6'd39));
    send_item(lcd_op(OP_CURSOR, 8'h00, 1'b1, 6'h3F));
    send_item(lcd_op(OP_CLEAR, 8'hFF, 1'b1, 6'h3F));
    send_item(lcd_op(3'd6, 8'h00, 1'b0, 6'd0));
    // init waits must keep the character pins just driven
    send_item(lcd_op(OP_CHAR, 8'h3C, 1'b0, 6'd0));
    send_item(lcd_op(OP_INIT, 8'hFF, 1'b1, 6'h3F));
    send_item(lcd_op(OP_LAST_UNUSED, 8'h5A, 1'b1, 6'h2A));
    send_item(lcd_op(OP_CMD, 8'h80, 1'b0, 6'd0));
    settle();

    // random operations over a few settings
    write_ticks(20'($urandom_range(2, 8)));
    random_chunk(30);
    settle();
    write_ticks(20'($urandom_range(1, 4)));
    random_chunk(25);
    settle();

    // last stretch at full rate on both sides
    write_ticks(20'd1);
    calm = 1'b1;
    random_chunk(15);
    settle();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

### char_lcd_nibble_sequencer_top.f
+incdir+rtl
rtl/chrlcd_pkg.sv
rtl/chrlcd_hold_timer.sv
rtl/char_lcd_nibble_sequencer_top.sv
rtl/chrlcd_checker.sv
test/tb.sv
